FILE: rtl/vtfd_pkg.sv
// Types, codes and constants shared by the typed field decoder modules.
package vtfd_pkg;

	localparam logic [7:0] NULL_MARKER = 8'hC0;
	localparam logic [5:0] MAX_HDR_LEN = 6'd8;

	typedef enum logic [3:0] {
		CMD_U8       = 4'd0,
		CMD_U16      = 4'd1,
		CMD_U32      = 4'd2,
		CMD_U64      = 4'd3,
		CMD_I8       = 4'd4,
		CMD_I16      = 4'd5,
		CMD_I32      = 4'd6,
		CMD_I64      = 4'd7,
		CMD_BOOL     = 4'd8,
		CMD_PRESENCE = 4'd9
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_RANGE     = 3'd1,
		ST_BAD_BOOL  = 3'd2,
		ST_BAD_PRES  = 3'd3,
		ST_BAD_LEN   = 3'd4,
		ST_TRUNCATED = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [3:0] command;
		logic       end_of_buffer;
	} in_beat_t;

	typedef struct packed {
		logic [63:0] value;
		logic        is_null;
		logic [3:0]  byte_count;
		logic [2:0]  status;
	} out_beat_t;

	typedef struct packed {
		logic      emit;
		out_beat_t beat;
	} step_res_t;

endpackage

FILE: rtl/vtfd_check.sv
// Range and rule check of a decoded value against its target type.
module vtfd_check (
	input  logic [3:0]       field_type,
	input  logic [63:0]      value,
	output vtfd_pkg::status_t status
);
	import vtfd_pkg::*;

	always_comb begin
		status = ST_OK;
		case (field_type)
			CMD_U8: begin
				if (|value[63:8]) status = ST_RANGE;
			end
			CMD_U16: begin
				if (|value[63:16]) status = ST_RANGE;
			end
			CMD_U32: begin
				if (|value[63:32]) status = ST_RANGE;
			end
			CMD_I8: begin
				if (!((&value[63:7]) || !(|value[63:7]))) status = ST_RANGE;
			end
			CMD_I16: begin
				if (!((&value[63:15]) || !(|value[63:15]))) status = ST_RANGE;
			end
			CMD_I32: begin
				if (!((&value[63:31]) || !(|value[63:31]))) status = ST_RANGE;
			end
			CMD_BOOL: begin
				if (|value[63:8]) status = ST_RANGE;
				else if (|value[7:1]) status = ST_BAD_BOOL;
			end
			CMD_PRESENCE: begin
				if (value != 64'd1) status = ST_BAD_PRES;
			end
			default: status = ST_OK;
		endcase
	end

endmodule

FILE: rtl/vtfd_step.sv
// Field state registers and the per-beat decode step.
module vtfd_step (
	input  logic                clk,
	input  logic                arst_n,
	input  vtfd_pkg::in_beat_t  beat,
	input  logic                advance,
	output vtfd_pkg::step_res_t res
);
	import vtfd_pkg::*;

	logic        in_field_q, in_field_n;
	logic [3:0]  bytes_left_q, bytes_left_n;
	logic [3:0]  bytes_seen_q, bytes_seen_n;
	logic        two_byte_q, two_byte_n;
	logic [63:0] acc_q, acc_n;
	logic [5:0]  hdr_low_q, hdr_low_n;
	logic [3:0]  field_type_q, field_type_n;

	logic        chk_en;
	logic [63:0] chk_val;
	logic [3:0]  chk_cnt;
	status_t     chk_status;
	logic        is_signed;
	logic [2:0]  idx;
	logic [3:0]  hdr_cnt;
	logic        sgn;

	assign field_type_n = in_field_q ? field_type_q : beat.command;
	assign is_signed = (field_type_n == CMD_I8) || (field_type_n == CMD_I16) ||
		(field_type_n == CMD_I32) || (field_type_n == CMD_I64);
	assign hdr_cnt = hdr_low_q[3:0];

	vtfd_check u_check (
		.field_type(field_type_n),
		.value     (chk_val),
		.status    (chk_status)
	);

	always_comb begin
		in_field_n   = in_field_q;
		bytes_left_n = bytes_left_q;
		bytes_seen_n = bytes_seen_q;
		two_byte_n   = two_byte_q;
		acc_n        = acc_q;
		hdr_low_n    = hdr_low_q;
		chk_en       = 1'b0;
		chk_val      = '0;
		chk_cnt      = '0;
		idx          = '0;
		sgn          = 1'b0;
		res          = '0;
		if (!in_field_q) begin
			hdr_low_n    = beat.data_byte[5:0];
			bytes_seen_n = 4'd1;
			if (!beat.data_byte[7]) begin
				chk_en  = 1'b1;
				chk_cnt = 4'd1;
				chk_val = {{57{is_signed & beat.data_byte[6]}}, beat.data_byte[6:0]};
			end else if (!beat.data_byte[6]) begin
				if (beat.end_of_buffer) begin
					res.emit            = 1'b1;
					res.beat.byte_count = 4'd1;
					res.beat.status     = ST_TRUNCATED;
				end else begin
					in_field_n   = 1'b1;
					two_byte_n   = 1'b1;
					bytes_left_n = 4'd1;
				end
			end else if (beat.data_byte == NULL_MARKER) begin
				res.emit            = 1'b1;
				res.beat.is_null    = 1'b1;
				res.beat.byte_count = 4'd1;
				res.beat.status     = ST_OK;
			end else if (beat.data_byte[5:0] > MAX_HDR_LEN) begin
				res.emit            = 1'b1;
				res.beat.byte_count = 4'd1;
				res.beat.status     = ST_BAD_LEN;
			end else if (beat.end_of_buffer) begin
				res.emit            = 1'b1;
				res.beat.byte_count = 4'd1;
				res.beat.status     = ST_TRUNCATED;
			end else begin
				in_field_n   = 1'b1;
				two_byte_n   = 1'b0;
				bytes_left_n = beat.data_byte[3:0];
				acc_n        = '0;
			end
		end else begin
			bytes_seen_n = bytes_seen_q + 4'd1;
			if (two_byte_q) begin
				chk_en  = 1'b1;
				chk_cnt = 4'd2;
				chk_val = {{50{is_signed & beat.data_byte[7]}}, beat.data_byte, hdr_low_q};
			end else begin
				idx = 3'(bytes_seen_n - 4'd2);
				for (int k = 0; k < 8; k++) begin
					if (idx == 3'(k)) acc_n[8*k +: 8] = acc_q[8*k +: 8] | beat.data_byte;
				end
				bytes_left_n = bytes_left_q - 4'd1;
				if (bytes_left_n == 4'd0) begin
					for (int k = 0; k < 8; k++) begin
						if (hdr_cnt == 4'(k + 1)) sgn = acc_n[8*k + 7];
					end
					chk_val = acc_n;
					for (int k = 0; k < 8; k++) begin
						if (4'(k) >= hdr_cnt && is_signed && sgn) chk_val[8*k +: 8] = 8'hFF;
					end
					chk_en  = 1'b1;
					chk_cnt = hdr_cnt + 4'd1;
				end else if (beat.end_of_buffer) begin
					res.emit            = 1'b1;
					res.beat.byte_count = bytes_seen_n;
					res.beat.status     = ST_TRUNCATED;
				end
			end
		end
		if (chk_en) begin
			res.emit            = 1'b1;
			res.beat.value      = chk_val;
			res.beat.byte_count = chk_cnt;
			res.beat.status     = chk_status;
		end
		if (res.emit) begin
			in_field_n   = 1'b0;
			bytes_left_n = '0;
			two_byte_n   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_field_q   <= 1'b0;
			bytes_left_q <= '0;
			bytes_seen_q <= '0;
			two_byte_q   <= 1'b0;
			acc_q        <= '0;
			hdr_low_q    <= '0;
			field_type_q <= '0;
		end else if (advance) begin
			in_field_q   <= in_field_n;
			bytes_left_q <= bytes_left_n;
			bytes_seen_q <= bytes_seen_n;
			two_byte_q   <= two_byte_n;
			acc_q        <= acc_n;
			hdr_low_q    <= hdr_low_n;
			field_type_q <= field_type_n;
		end
	end

endmodule

FILE: rtl/vlc_typed_field_decoder.sv
// Top level of the typed variable-length field decoder.
// A completing beat is held in the input register, its result in the result register.
// Throughput: one byte beat per cycle while no finished beat is blocked; the
// input and result registers let a new beat enter while a finished result waits.
// Reset: arst_n clears the field state and both valid flags; the decoder
// then waits for a field header.
module vlc_typed_field_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_ready,
	input  vtfd_pkg::in_beat_t  byte_beat,
	output logic                field_valid,
	input  logic                field_ready,
	output vtfd_pkg::out_beat_t field_beat
);
	import vtfd_pkg::*;

	logic      valid_s1;
	in_beat_t  beat_s1;
	logic      valid_s2;
	out_beat_t beat_s2;
	step_res_t res;
	logic      out_free;
	logic      advance;

	assign out_free   = !valid_s2 || field_ready;
	assign advance    = valid_s1 && (!res.emit || out_free);
	assign byte_ready = !valid_s1 || advance;

	vtfd_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.beat   (beat_s1),
		.advance(advance),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) beat_s1 <= byte_beat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && res.emit) begin
			valid_s2 <= 1'b1;
		end else if (field_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.emit) beat_s2 <= res.beat;
	end

	assign field_valid = valid_s2;
	assign field_beat  = beat_s2;

	a_hold_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res.emit && !out_free |-> !byte_ready)
		else $error("input taken while result path blocked");

	a_null_clean: assert property (@(posedge clk) disable iff (!arst_n)
		field_valid && field_beat.is_null |->
		field_beat.status == ST_OK && field_beat.value == 64'd0 && field_beat.byte_count == 4'd1)
		else $error("null result malformed");

	a_trunc_clean: assert property (@(posedge clk) disable iff (!arst_n)
		field_valid && (field_beat.status == ST_TRUNCATED || field_beat.status == ST_BAD_LEN) |->
		field_beat.value == 64'd0 && !field_beat.is_null)
		else $error("error result carries data");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		field_valid |-> field_beat.byte_count != 4'd0 && field_beat.byte_count <= 4'd9)
		else $error("byte count out of range");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.emit |=> field_valid)
		else $error("emitted result lost");

endmodule
